@@ sv/clos_pkg.sv @@
// Shared types, limits and codes of the 5x5 binary closing core.
package clos_pkg;

   // Frame geometry limits
   localparam int MAX_LINE  = 1024;
   localparam int MAX_LINES = 4096;
   localparam int MIN_DIM   = 5;

   // Register field widths
   localparam int WID_W = 11;
   localparam int HGT_W = 13;
   localparam int THR_W = 8;
   localparam int PIX_W = 8;

   // Column index and stream row counter (rows run four past the frame while draining)
   localparam int COL_W = $clog2(MAX_LINE);
   localparam int ROW_W = $clog2(MAX_LINES + 4);

   // Each line store word keeps the four previous rows of one column
   localparam int LINE_BITS = 4;
   localparam int WIN_ROWS  = LINE_BITS + 1;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH = 2'd2;

   // Register reset values
   localparam logic [WID_W-1:0] WID_RESET = 11'd640;
   localparam logic [HGT_W-1:0] HGT_RESET = 13'd480;
   localparam logic [THR_W-1:0] THR_RESET = 8'd128;

   // Request operations
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Output pixel levels
   localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
   localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

   typedef struct packed {
      logic             operation;
      logic [PIX_W-1:0] grey_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             last_of_frame;
   } rsp_type;

   // Sequencer status toward the datapath
   typedef struct packed {
      logic             step;       // request advances the stream
      logic             emit;       // step releases one result
      logic             last;       // result closes the frame
      logic             dil_int;    // dilated pixel two rows up is interior
      logic             out_int;    // output pixel four rows up is interior
      logic [COL_W-1:0] col;        // current column, line store write address
      logic [COL_W-1:0] rd_addr;    // column prefetched for the next step
      logic [THR_W-1:0] threshold;
   } seq_type;

   // Neighborhood results of one window cell
   typedef struct packed {
      logic all_set;   // all 12 neighbors are 1
      logic any_set;   // any of the 12 neighbors is 1
      logic tail;      // oldest row of the current column
   } win_type;

endpackage

@@ sv/clos_ram.sv @@
// Generic simple dual-port RAM with registered read.
module clos_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/clos_window.sv @@
// One 5x5 window cell: column registers, line store and 12-neighbor reductions.
module clos_window import clos_pkg::*; (
   input  logic             clock,
   input  logic             step,
   input  logic             bit_in,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [COL_W-1:0] rd_addr,
   output win_type          win
);

   // Line word bit j holds row r-1-j; window column bit k holds row r-k
   logic [LINE_BITS-1:0] cp2;
   logic [LINE_BITS-1:0] c1_ff, c1_in;
   logic [LINE_BITS-1:0] c0_ff, c0_in;
   logic [WIN_ROWS-1:0]  cm1_ff, cm1_in;
   logic [WIN_ROWS-1:0]  cm2_ff, cm2_in;
   logic [LINE_BITS-1:0] line_wr;
   logic [11:0]          nbr;

   clos_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_LINE)
   ) u_line (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (wr_addr),
      .wr_data (line_wr),
      .rd_en   (step),
      .rd_addr (rd_addr),
      .rd_data (cp2)
   );

   // Push the current row into the column word
   assign line_wr = {c0_ff[LINE_BITS-2:0], bit_in};

   // Neighbors of the pixel two rows up in the current column
   assign nbr = {
      c0_ff[3],
      cm1_ff[3], c0_ff[2], c1_ff[2],
      cm2_ff[2], cm1_ff[2], c1_ff[1], cp2[1],
      cm1_ff[1], c0_ff[0], c1_ff[0],
      bit_in
   };

   assign win.all_set = &nbr;
   assign win.any_set = |nbr;
   assign win.tail    = c0_ff[3];

   always_comb begin
      cm2_in = cm1_ff;
      cm1_in = {c0_ff, bit_in};
      c0_in  = c1_ff;
      c1_in  = cp2;
   end

   always_ff @(posedge clock) begin
      if (step) begin
         cm2_ff <= cm2_in;
         cm1_ff <= cm1_in;
         c0_ff  <= c0_in;
         c1_ff  <= c1_in;
      end
   end

endmodule

@@ sv/clos_seq.sv @@
// Configuration registers and stream position sequencer.
module clos_seq import clos_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   input  logic                  req_op,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output seq_type               seq
);

   logic [WID_W-1:0] wid_ff, wid_in;
   logic [COL_W-1:0] wm1_ff, wm1_in;
   logic [COL_W-1:0] wm3_ff, wm3_in;
   logic [HGT_W-1:0] hgt_ff, hgt_in;
   logic [ROW_W-1:0] hp3_ff, hp3_in;
   logic [THR_W-1:0] thr_ff, thr_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [WID_W-1:0] wid_wr;
   logic [HGT_W-1:0] hgt_wr;
   logic [WID_W-1:0] wm1_full;
   logic [WID_W-1:0] wm3_full;
   logic [ROW_W-1:0] hp2;
   logic             geom_wr;
   logic             in_done;
   logic             col_mid;
   logic             row_end;
   logic             step;
   logic [WID_W-1:0] rd_sum;
   logic [WID_W-1:0] rd_wrap;

   // Clamp geometry on write
   always_comb begin
      wid_wr = csr_wdata[WID_W-1:0];
      if (wid_wr < WID_W'(MIN_DIM)) begin
         wid_wr = WID_W'(MIN_DIM);
      end else if (wid_wr > WID_W'(MAX_LINE)) begin
         wid_wr = WID_W'(MAX_LINE);
      end
      hgt_wr = csr_wdata[HGT_W-1:0];
      if (hgt_wr < HGT_W'(MIN_DIM)) begin
         hgt_wr = HGT_W'(MIN_DIM);
      end else if (hgt_wr > HGT_W'(MAX_LINES)) begin
         hgt_wr = HGT_W'(MAX_LINES);
      end
   end

   assign wm1_full = wid_wr - WID_W'(1);
   assign wm3_full = wid_wr - WID_W'(3);

   always_comb begin
      wid_in  = wid_ff;
      wm1_in  = wm1_ff;
      wm3_in  = wm3_ff;
      hgt_in  = hgt_ff;
      hp3_in  = hp3_ff;
      thr_in  = thr_ff;
      geom_wr = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH: begin
               wid_in  = wid_wr;
               wm1_in  = wm1_full[COL_W-1:0];
               wm3_in  = wm3_full[COL_W-1:0];
               geom_wr = 1'b1;
            end
            CSR_HEIGHT: begin
               hgt_in  = hgt_wr;
               hp3_in  = ROW_W'(hgt_wr) + ROW_W'(3);
               geom_wr = 1'b1;
            end
            CSR_THRESH: begin
               thr_in = csr_wdata[THR_W-1:0];
            end
            default: begin
               thr_in = thr_ff;
            end
         endcase
      end
   end

   // Stream position: rows past the frame height are drain rows
   assign in_done = row_ff >= ROW_W'(hgt_ff);
   assign hp2     = ROW_W'(hgt_ff) + ROW_W'(2);
   assign col_mid = (col_ff >= COL_W'(2)) && (col_ff <= wm3_ff);
   assign row_end = col_ff == wm1_ff;

   assign step = req_fire &&
                 (((req_op == OP_PIXEL) && !in_done) || ((req_op == OP_DRAIN) && in_done));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (geom_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (step) begin
         if (row_end && (row_ff == hp3_ff)) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // Prefetch two columns ahead of the next step
   assign rd_sum  = {1'b0, col_in} + WID_W'(2);
   assign rd_wrap = (rd_sum >= wid_ff) ? (rd_sum - wid_ff) : rd_sum;

   assign seq.step      = step;
   assign seq.emit      = step && (row_ff >= ROW_W'(4));
   assign seq.last      = row_end && (row_ff == hp3_ff);
   assign seq.dil_int   = col_mid && (row_ff >= ROW_W'(4)) && !in_done;
   assign seq.out_int   = col_mid && (row_ff >= ROW_W'(6)) && (row_ff < hp2);
   assign seq.col       = col_ff;
   assign seq.rd_addr   = rd_wrap[COL_W-1:0];
   assign seq.threshold = thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wid_ff <= WID_RESET;
         wm1_ff <= COL_W'(WID_RESET - WID_W'(1));
         wm3_ff <= COL_W'(WID_RESET - WID_W'(3));
         hgt_ff <= HGT_RESET;
         hp3_ff <= ROW_W'(HGT_RESET) + ROW_W'(3);
         thr_ff <= THR_RESET;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         wid_ff <= wid_in;
         wm1_ff <= wm1_in;
         wm3_ff <= wm3_in;
         hgt_ff <= hgt_in;
         hp3_ff <= hp3_in;
         thr_ff <= thr_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ sv/binary_morph_closing_5x5_core.sv @@
// Top level: streaming 5x5 binary closing (dilate then erode, black foreground).
// Throughput: one request per cycle while req_stall is low. Each result is registered
// in the output register, or in the skid stage while the output is stalled. A pixel
// four lines below releases each output; drains release the last four lines. The two
// window cells and their line stores, one read and one write port each, set the pace.
// Reset restores the registers and frame position; line stores are not cleared.
module binary_morph_closing_5x5_core import clos_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   seq_type seq;
   win_type win_bin;
   win_type win_dil;

   logic    req_fire;
   logic    bin_bit;
   logic    dil_bit;
   logic    white;
   rsp_type new_rsp;
   logic    rsp_take;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   // Hold off requests only while the skid stage is occupied
   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;

   clos_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_op    (req_data.operation),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .seq       (seq)
   );

   // Binarize: 1 is white, 0 is black
   assign bin_bit = req_data.grey_in >= seq.threshold;

   // First cell: dilation of black, i.e. white survives only if all neighbors are white
   clos_window u_win_bin (
      .clock   (clock),
      .step    (seq.step),
      .bit_in  (bin_bit),
      .wr_addr (seq.col),
      .rd_addr (seq.rd_addr),
      .win     (win_bin)
   );

   // Edge pixels of the dilated image count as black
   assign dil_bit = seq.dil_int && win_bin.all_set;

   // Second cell: erosion of black, i.e. white if any dilated neighbor is white
   clos_window u_win_dil (
      .clock   (clock),
      .step    (seq.step),
      .bit_in  (dil_bit),
      .wr_addr (seq.col),
      .rd_addr (seq.rd_addr),
      .win     (win_dil)
   );

   // Output edge pixels keep their binarized value
   assign white = seq.out_int ? win_dil.any_set : win_bin.tail;

   assign new_rsp.pixel_out     = white ? PIX_WHITE : PIX_BLACK;
   assign new_rsp.last_of_frame = seq.last;

   // Output register with a skid stage behind it
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // No request can arrive here; advance the skid entry once the output drains
         if (rsp_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_take) begin
         rsp_valid_in = seq.emit;
         if (seq.emit) begin
            rsp_data_in = new_rsp;
         end
      end else if (seq.emit) begin
         // Output is stalled: park the new result
         skid_valid_in = 1'b1;
         skid_data_in  = new_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the 5x5 binary closing core: paced streams against a predictor.
module tb_top;
   import clos_pkg::*;

   // Unmapped register index, written once to show that it changes nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam int RING_ROWS       = 16;    // predictor keeps the last 16 binarized lines
   localparam int MAX_GAP         = 12;    // longest idle stretch drawn per request or result
   localparam int HOLD_CYCLES     = 300;   // long receiver hold-off that backs up the core
   localparam int SETTLE_CYCLES   = 8;     // quiet time before a register write
   localparam int QUIET_LIMIT     = 2000;  // watchdog: cycles with nothing moving
   localparam int RANDOM_REQUESTS = 700;
   localparam int MAX_REPORTS     = 50;

   // Structuring element: +-1 and +-2 along each axis plus the four diagonals
   int nb_dx [0:11] = '{-1, -2, 1, 2, 0, 0, 0, 0, 1, -1, 1, -1};
   int nb_dy [0:11] = '{0, 0, 0, 0, -1, -2, 1, 2, 1, 1, -1, -1};

   // Grey values around the reset threshold and with alternating bit patterns
   logic [PIX_W-1:0] boundary_greys [0:10] =
      '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255, 8'h55, 8'hAA, 8'h0F, 8'hF0};

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   binary_morph_closing_5x5_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------------------
   // Closing predictor: its own copy of the registers, frame positions and line ring
   // ---------------------------------------------------------------------------------
   bit               line_ring [RING_ROWS][MAX_LINE];   // 1 = white
   int               in_pos;
   int               out_pos;
   logic [WID_W-1:0] width_reg;
   logic [HGT_W-1:0] height_reg;
   logic [THR_W-1:0] thresh_reg;

   rsp_type closed_q  [$];   // closed pixels expected from the core, oldest first
   req_type request_q [$];   // requests waiting for the driver

   // Pacing and bookkeeping
   bit send_idle   = 1'b0;
   bit recv_idle   = 1'b0;
   int hold_ticket = 0;
   int holds_served;
   int hold_left;
   int hold_now;
   int rsp_wait;
   int wait_now;
   int send_gap;
   int quiet_cycles;
   int errors          = 0;
   int results_checked = 0;
   int frames_closed   = 0;
   int pixels_taken    = 0;
   int drains_taken    = 0;
   int csr_writes      = 0;
   int stream_requests = 0;
   int random_start;
   bit reshape;

   function automatic int line_len();
      if (width_reg < WID_W'(MIN_DIM)) return MIN_DIM;
      if (int'(width_reg) > MAX_LINE) return MAX_LINE;
      return int'(width_reg);
   endfunction

   function automatic int frame_lines();
      if (height_reg < HGT_W'(MIN_DIM)) return MIN_DIM;
      if (int'(height_reg) > MAX_LINES) return MAX_LINES;
      return int'(height_reg);
   endfunction

   function automatic bit bin_at(int x, int y);
      if (x < 0 || x >= MAX_LINE || y < 0) return 1'b0;
      return line_ring[y % RING_ROWS][x];
   endfunction

   function automatic bit is_interior(int x, int y, int w, int h);
      return x >= 2 && y >= 2 && x + 2 < w && y + 2 < h;
   endfunction

   // Dilation of black: white only if all 12 neighbors are white; frame border is black
   function automatic bit dilated_white(int x, int y, int w, int h);
      if (!is_interior(x, y, w, h)) return 1'b0;
      for (int k = 0; k < 12; k++)
         if (!bin_at(x + nb_dx[k], y + nb_dy[k])) return 1'b0;
      return 1'b1;
   endfunction

   // Erode the dilated image at the output position and queue the closed pixel
   function automatic void release_closed(int w, int h);
      int      x;
      int      y;
      bit      white;
      rsp_type r;
      x = out_pos % w;
      y = out_pos / w;
      white = 1'b0;
      if (is_interior(x, y, w, h)) begin
         for (int k = 0; k < 12; k++)
            if (dilated_white(x + nb_dx[k], y + nb_dy[k], w, h)) white = 1'b1;
      end else begin
         white = bin_at(x, y);   // border pixels pass their binarized value
      end
      out_pos++;
      r.pixel_out     = white ? PIX_WHITE : PIX_BLACK;
      r.last_of_frame = 1'b0;
      if (out_pos >= w * h) begin
         r.last_of_frame = 1'b1;
         in_pos  = 0;
         out_pos = 0;
      end
      closed_q.push_back(r);
   endfunction

   // Advance the predictor by one accepted request
   function automatic void closing_step(req_type r);
      int w;
      int h;
      int total;
      int x;
      int y;
      w = line_len();
      h = frame_lines();
      total = w * h;
      if (r.operation == OP_PIXEL) begin
         if (in_pos >= total) return;   // frame complete, outputs pending: drop it
         x = in_pos % w;
         y = in_pos / w;
         line_ring[y % RING_ROWS][x] = (r.grey_in >= thresh_reg);
         in_pos++;
         if (in_pos > 4 * w) release_closed(w, h);
      end else if (in_pos >= total && out_pos < total) begin
         release_closed(w, h);
      end
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_WIDTH: begin
            width_reg = data[WID_W-1:0];
            in_pos    = 0;   // geometry change abandons the frame
            out_pos   = 0;
         end
         CSR_HEIGHT: begin
            height_reg = data[HGT_W-1:0];
            in_pos     = 0;
            out_pos    = 0;
         end
         CSR_THRESH: begin
            thresh_reg = data[THR_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void reset_predictor();
      foreach (line_ring[r, c]) line_ring[r][c] = 1'b0;
      in_pos     = 0;
      out_pos    = 0;
      width_reg  = WID_RESET;
      height_reg = HGT_RESET;
      thresh_reg = THR_RESET;
   endfunction

   // ---------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------
   task automatic report_mismatch(string what);
      // keep the log short when the core is badly off; every mismatch still counts
      if (errors < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, what);
      errors++;
   endtask

   task automatic check_closed(rsp_type got);
      rsp_type want;
      if (closed_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result pixel_out %0d last_of_frame %0b",
                                   got.pixel_out, got.last_of_frame));
         return;
      end
      want = closed_q.pop_front();
      if (got.pixel_out !== want.pixel_out)
         report_mismatch($sformatf("result %0d: pixel_out %0d, expected %0d",
                                   results_checked, got.pixel_out, want.pixel_out));
      if (got.last_of_frame !== want.last_of_frame)
         report_mismatch($sformatf("result %0d: last_of_frame %0b, expected %0b",
                                   results_checked, got.last_of_frame, want.last_of_frame));
      if (want.last_of_frame) frames_closed++;
      results_checked++;
   endtask

   // ---------------------------------------------------------------------------------
   // Driver: predict each accepted request, then offer the next one after a drawn gap
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            closing_step(req_data);
            if (req_data.operation == OP_PIXEL) pixels_taken++;
            else drains_taken++;
         end
         // hold a stalled request unchanged; otherwise advance
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (request_q.size() != 0) begin
               req_data  <= request_q.pop_front();
               req_valid <= 1'b1;
               send_gap  <= send_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Monitor: check each accepted result, then stall for a drawn number of cycles;
   // a new hold ticket stalls for a long stretch so the core backs up
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         rsp_wait     <= 0;
         hold_left    <= 0;
         holds_served <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_closed(rsp_data);
            wait_now = recv_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
         end else begin
            wait_now = rsp_wait;
         end
         if (hold_ticket != holds_served) begin
            holds_served <= hold_ticket;
            hold_now = HOLD_CYCLES;
         end else begin
            hold_now = hold_left;
         end
         if (hold_now > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_now - 1;
            rsp_wait  <= wait_now;
         end else if (wait_now > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= 0;
            rsp_wait  <= wait_now - 1;
         end else begin
            rsp_stall <= 1'b0;
            hold_left <= 0;
            rsp_wait  <= 0;
         end
      end
   end

   // Watchdog: end the run when neither channel nor the register port moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
                  quiet_cycles, closed_q.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers; queue pushes and pacing changes happen at the falling edge
   // ---------------------------------------------------------------------------------
   function automatic void push_request(logic op, logic [PIX_W-1:0] grey);
      req_type r;
      r.operation = op;
      r.grey_in   = grey;
      request_q.push_back(r);
   endfunction

   // Grey value that is black with chance dens/16; a negative dens draws any value
   function automatic logic [PIX_W-1:0] pick_grey(int dens);
      if (dens < 0 || thresh_reg == '0) return PIX_W'($urandom);
      if (int'($urandom_range(0, 15)) < dens)
         return PIX_W'($urandom_range(0, int'(thresh_reg) - 1));
      return PIX_W'($urandom_range(int'(thresh_reg), 255));
   endfunction

   // Wait until every request is taken and every expected result has come
   task automatic wait_drained();
      while (request_q.size() != 0 || req_valid || closed_q.size() != 0) @(negedge clock);
   endtask

   // Drained, plus time for a request that releases nothing to clear the core
   task automatic wait_idle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_register(idx, data);
      csr_writes++;
   endtask

   // Register writes carry random bits above the field so every data bit toggles
   task automatic set_width(int w);
      logic [CSR_DATA_W-1:0] v;
      v = CSR_DATA_W'($urandom);
      v[WID_W-1:0] = WID_W'(w);
      csr_write(CSR_WIDTH, v);
   endtask

   task automatic set_height(int h);
      csr_write(CSR_HEIGHT, CSR_DATA_W'(h));
   endtask

   task automatic set_thresh(int t);
      logic [CSR_DATA_W-1:0] v;
      v = CSR_DATA_W'($urandom);
      v[THR_W-1:0] = THR_W'(t);
      csr_write(CSR_THRESH, v);
   endtask

   task automatic pace(bit s, bit r);
      @(negedge clock);
      send_idle = s;
      recv_idle = r;
   endtask

   // Queue one frame: pixels, then the drains that flush it. Noise adds requests the
   // core must drop (drain mid-frame, pixel while outputs pend, drain with nothing
   // pending). Split pauses the sender halfway until all results are in, and may
   // change the threshold there. A nonzero cut stops after that many pixels; the
   // caller then rewrites the geometry to abandon the frame.
   task automatic send_frame(int dens, bit noisy, bit split, int cut);
      int w;
      int h;
      int total;
      int n_pix;
      int drains;
      w = line_len();
      h = frame_lines();
      total = w * h;
      n_pix = (cut > 0 && cut < total) ? cut : total;
      @(negedge clock);
      for (int i = 0; i < n_pix; i++) begin
         if (noisy && $urandom_range(0, 15) == 0) push_request(OP_DRAIN, PIX_W'($urandom));
         push_request(OP_PIXEL, pick_grey(dens));
         if (split && i == n_pix / 2) begin
            wait_idle();
            if ($urandom_range(0, 1) == 1) begin
               set_thresh(int'($urandom_range(0, 255)));
               @(negedge clock);
            end
         end
      end
      stream_requests += n_pix;
      if (n_pix < total) return;
      drains = (total > 4 * w) ? 4 * w : total;
      for (int i = 0; i < drains; i++) begin
         if (noisy && $urandom_range(0, 7) == 0) push_request(OP_PIXEL, PIX_W'($urandom));
         push_request(OP_DRAIN, PIX_W'($urandom));
      end
      if (noisy) push_request(OP_DRAIN, PIX_W'($urandom));
      stream_requests += drains;
   endtask

   // ---------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------
   initial begin
      reset_predictor();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry (640 x 480) and threshold: drain with nothing pending, grey
      // values around the threshold, a drain mid-frame, then a partial frame that
      // stops before any output; pause halfway, then abandon the frame.
      pace(1'b1, 1'b1);
      push_request(OP_DRAIN, 8'hFF);
      foreach (boundary_greys[i]) push_request(OP_PIXEL, boundary_greys[i]);
      push_request(OP_DRAIN, 8'h00);
      send_frame(4, 1'b1, 1'b1, 160);
      wait_idle();

      // Out-of-range geometry clamps to the 5 x 5 minimum; white only at 255
      set_width(0);
      set_height(4);
      set_thresh(255);
      csr_write(CSR_SPARE, CSR_DATA_W'($urandom));
      pace(1'b1, 1'b1);
      send_frame(-1, 1'b1, 1'b0, 0);
      wait_idle();

      // Back-pressure: a tall narrow frame offered back to back while the receiver holds
      set_thresh(128);
      set_width(5);
      set_height(40);
      pace(1'b0, 1'b1);
      hold_ticket++;
      send_frame(3, 1'b0, 1'b0, 0);
      wait_idle();

      // Widest line: 2047 clamps to the maximum line length; a partial frame, then abandon
      set_width(2047);
      set_height(5);
      pace(1'b1, 1'b1);
      send_frame(2, 1'b0, 1'b1, 160);
      wait_idle();

      // Tallest frame: 8191 clamps to the maximum line count; everything white at 0
      set_width(5);
      set_height(8191);
      set_thresh(0);
      pace(1'b1, 1'b0);
      send_frame(-1, 1'b0, 1'b0, 300);
      wait_idle();
      reshape = 1'b1;

      // Random frames: small geometry, random pacing, noise, splits and abandoned frames
      random_start = stream_requests;
      while (stream_requests - random_start < RANDOM_REQUESTS) begin
         int w_pick;
         int h_pick;
         int t_pick;
         int dens;
         int cut;
         int total;
         if (reshape || $urandom_range(0, 2) == 0) begin
            w_pick = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 4))
                                                 : int'($urandom_range(5, 24));
            set_width(w_pick);
         end
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
               0:       h_pick = int'($urandom_range(0, 4));
               1:       h_pick = int'($urandom_range(13, 40));
               default: h_pick = int'($urandom_range(5, 12));
            endcase
            set_height(h_pick);
         end
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0:       t_pick = 0;
               1:       t_pick = 255;
               default: t_pick = int'($urandom_range(1, 254));
            endcase
            set_thresh(t_pick);
         end
         dens  = ($urandom_range(0, 7) == 0) ? -1 : int'($urandom_range(0, 5));
         total = line_len() * frame_lines();
         cut   = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, total - 1)) : 0;
         pace($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
         send_frame(dens, $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0, cut);
         wait_idle();
         reshape = (cut > 0);
      end

      // Drain the tail and give the core time to show any stray result
      wait_drained();
      repeat (4 * SETTLE_CYCLES) @(negedge clock);
      if (closed_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", closed_q.size()));

      $display("Run: %0d pixel and %0d drain requests, %0d closed pixels checked, %0d frames.",
               pixels_taken, drains_taken, results_checked, frames_closed);
      $display("Geometry from clamped 5x5 up to 1024-wide and 4096-line, %0d register writes.",
               csr_writes);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
